[sv/stq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sleep timer queue package
// Shared constants, command and result codes, controller states and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam int          TIME_W     = 32;
  localparam logic [31:0] RESET_TIME = 32'd17;

  // at most this many wake notices per tick
  localparam int MAX_WAKES  = 16;
  localparam int WAKE_CNT_W = $clog2(MAX_WAKES + 1);

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_SLEEP = 2'd2;

  localparam logic [1:0] KIND_WAKE   = 2'd0;
  localparam logic [1:0] KIND_TIME   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_WAKE,
    ST_REPLY,
    ST_SUM,
    ST_INSERT
  } state_t;

  typedef struct packed {
    logic capture;
    logic inc_time;
    logic sum_time;
    logic insert;
    logic pop;
    logic emit_reply;
    logic emit_reject;
  } dp_cmd_t;

  typedef struct packed {
    logic table_full;
    logic head_due;
    logic next_due;
  } dp_status_t;

endpackage
`default_nettype wire

[sv/stq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sleep timer queue controller
// Sequences tick, time query and sleep request words through the datapath.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [1:0]          in_cmd,
  input  wire stq_pkg::dp_status_t status,
  output stq_pkg::dp_cmd_t         cmd,
  output logic                     busy
);
  import stq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (in_cmd)
            CMD_TICK:  state_nxt = ST_TICK;
            CMD_QUERY: state_nxt = ST_REPLY;
            CMD_SLEEP: state_nxt = ST_SUM;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        cmd.inc_time = 1'b1;
        state_nxt    = ST_WAKE;
      end
      ST_WAKE: begin
        if (status.head_due) begin
          cmd.pop = 1'b1;
          if (!status.next_due) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPLY: begin
        cmd.emit_reply = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SUM: begin
        cmd.sum_time = 1'b1;
        state_nxt    = ST_INSERT;
      end
      ST_INSERT: begin
        if (status.table_full) begin
          cmd.emit_reject = 1'b1;
        end else begin
          cmd.insert = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.inc_time, cmd.sum_time, cmd.insert, cmd.pop,
              cmd.emit_reply, cmd.emit_reject}))
    else $error("more than one datapath command at once");

  a_wake_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.inc_time |=> state_r == ST_WAKE)
    else $error("time advance not followed by wake scan");

  a_insert_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert || cmd.emit_reject) |-> $past(cmd.sum_time))
    else $error("insert without a fresh wake time");

endmodule
`default_nettype wire

[sv/stq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sleep timer queue datapath
// Time counter, sorted sleeper table with shift insert and head removal,
// wake count and the registered result word.
// ----------------------------------------------------------------------------
module stq_dp #(
  parameter int TABLE_DEPTH = stq_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = stq_pkg::ID_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire stq_pkg::dp_cmd_t           cmd,
  input  wire logic [ID_BITS-1:0]         in_requester_id,
  input  wire logic [stq_pkg::TIME_W-1:0] in_duration,
  output stq_pkg::dp_status_t             status,
  output logic                            out_valid,
  output logic [1:0]                      out_kind,
  output logic [ID_BITS-1:0]              out_target_id,
  output logic [stq_pkg::TIME_W-1:0]      out_time_value,
  output logic                            out_last
);
  import stq_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [TIME_W-1:0]     now_r;
  logic [TIME_W-1:0]     t_r;
  logic [TIME_W-1:0]     dur_r;
  logic [ID_BITS-1:0]    rid_r;
  logic [CNT_W-1:0]      count_r;
  logic [WAKE_CNT_W-1:0] woken_r;

  logic [TIME_W-1:0]  wake_r    [TABLE_DEPTH];
  logic [ID_BITS-1:0] sid_r     [TABLE_DEPTH];
  logic [TIME_W-1:0]  wake_nxt  [TABLE_DEPTH];
  logic [ID_BITS-1:0] sid_nxt   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] after;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [TIME_W-1:0] out_tv_r;
  logic              out_last_r;

  // full flag and due checks on the two leading entries
  always_comb begin
    status.table_full = (count_r == CNT_W'(TABLE_DEPTH));
    status.head_due   = (count_r != '0) && (wake_r[0] <= now_r)
                        && (woken_r < WAKE_CNT_W'(MAX_WAKES));
    status.next_due   = (count_r > CNT_W'(1)) && (wake_r[1] <= now_r)
                        && ((woken_r + WAKE_CNT_W'(1)) < WAKE_CNT_W'(MAX_WAKES));
  end

  // entry i stays in place when the new word goes after it; a pop shifts entries toward the head
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) begin
        after[i] = (count_r != '0) && (t_r >= wake_r[0]);
      end else begin
        after[i] = (CNT_W'(i) < count_r) && (t_r > wake_r[i]);
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd.insert) begin
        if (after[i]) begin
          wake_nxt[i] = wake_r[i];
          sid_nxt[i]  = sid_r[i];
        end else if (i == 0) begin
          wake_nxt[i] = t_r;
          sid_nxt[i]  = rid_r;
        end else if (after[i-1]) begin
          wake_nxt[i] = t_r;
          sid_nxt[i]  = rid_r;
        end else begin
          wake_nxt[i] = wake_r[i-1];
          sid_nxt[i]  = sid_r[i-1];
        end
      end else if (cmd.pop && (i < TABLE_DEPTH - 1)) begin
        wake_nxt[i] = wake_r[i+1];
        sid_nxt[i]  = sid_r[i+1];
      end else begin
        wake_nxt[i] = wake_r[i];
        sid_nxt[i]  = sid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wake_r[i] <= wake_nxt[i];
      sid_r[i]  <= sid_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= RESET_TIME;
      count_r     <= '0;
      woken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.inc_time) begin
        now_r   <= now_r + TIME_W'(1);
        woken_r <= '0;
      end
      if (cmd.pop) begin
        woken_r <= woken_r + WAKE_CNT_W'(1);
        count_r <= count_r - CNT_W'(1);
      end else if (cmd.insert) begin
        count_r <= count_r + CNT_W'(1);
      end
      out_valid_r <= cmd.pop || cmd.emit_reply || cmd.emit_reject;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rid_r <= in_requester_id;
      dur_r <= in_duration;
    end
    if (cmd.sum_time) begin
      t_r <= now_r + dur_r;
    end
    if (cmd.pop) begin
      out_kind_r <= KIND_WAKE;
      out_id_r   <= sid_r[0];
      out_tv_r   <= wake_r[0];
      out_last_r <= !status.next_due;
    end else if (cmd.emit_reply) begin
      out_kind_r <= KIND_TIME;
      out_id_r   <= rid_r;
      out_tv_r   <= now_r;
      out_last_r <= 1'b1;
    end else if (cmd.emit_reject) begin
      out_kind_r <= KIND_REJECT;
      out_id_r   <= rid_r;
      out_tv_r   <= t_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_target_id  = out_id_r;
  assign out_time_value = out_tv_r;
  assign out_last       = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("head removed from an empty table");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the table by one");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (wake_r[0] <= wake_r[1]))
    else $error("leading entries out of order");

endmodule
`default_nettype wire

[sv/sleep_timer_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sleep timer queue
// Time service with a sleeper table kept sorted by wake time.
// ----------------------------------------------------------------------------
// A time reply is registered out of the reply state that follows the word
//   being taken; a tick first advances the time, then the wake state
//   removes due heads and registers one notice per cycle. A sleep request
//   passes through the sum and insert states. The controller takes no new
//   word until idle again; it walks the table head one entry per cycle.
// Reset: time returns to 17 and the table empties; table contents are not
//   cleared, only the entry count. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module sleep_timer_queue #(
  parameter int TABLE_DEPTH = stq_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = stq_pkg::ID_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [ID_BITS-1:0]         in_requester_id,
  input  wire logic [stq_pkg::TIME_W-1:0] in_duration,
  output logic                            out_valid,
  output logic [1:0]                      out_kind,
  output logic [ID_BITS-1:0]              out_target_id,
  output logic [stq_pkg::TIME_W-1:0]      out_time_value,
  output logic                            out_last
);
  import stq_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // controller: decode the incoming word and step through its phases
  stq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .status (dp_status),
    .cmd    (dp_cmd),
    .busy   (busy)
  );

  // datapath: hold the time, the sorted table and the outgoing result word
  stq_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .in_requester_id (in_requester_id),
    .in_duration     (in_duration),
    .status          (dp_status),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_target_id   (out_target_id),
    .out_time_value  (out_time_value),
    .out_last        (out_last)
  );

  // a strobe always carries a legal result code
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_WAKE || out_kind == KIND_TIME ||
                   out_kind == KIND_REJECT))
    else $error("result strobe with an unused code");

  // replies and rejects are always the only result of their word
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_WAKE) |-> out_last)
    else $error("reply or reject not marked last");

  // no word may be taken while a wake burst is still running
  a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("idle in the middle of a wake burst");

endmodule
`default_nettype wire

[tb/stq_mail_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep timer queue result checker
// Watches the request and result channels, keeps its own copy of the time
// and the sorted sleeper table, and compares every result with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module stq_mail_check (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic [1:0]                          in_cmd,
  input  wire logic [stq_pkg::ID_BITS_DEF-1:0]     in_requester_id,
  input  wire logic [stq_pkg::TIME_W-1:0]          in_duration,
  input  wire logic                                out_valid,
  input  wire logic [1:0]                          out_kind,
  input  wire logic [stq_pkg::ID_BITS_DEF-1:0]     out_target_id,
  input  wire logic [stq_pkg::TIME_W-1:0]          out_time_value,
  input  wire logic                                out_last,
  output int                                       fail_count,
  output int                                       pending,
  output int                                       wake_count,
  output int                                       reject_count,
  output int                                       peak_wakes
);
  import stq_pkg::*;

  typedef struct packed {
    logic [1:0]             kind;
    logic [ID_BITS_DEF-1:0] target;
    logic [TIME_W-1:0]      stamp;
    logic                   last;
  } mail_t;

  mail_t                  pending_mail[$];
  logic [TIME_W-1:0]      clock_now;
  logic [TIME_W-1:0]      slot_time[TABLE_DEPTH_DEF];
  logic [ID_BITS_DEF-1:0] slot_id[TABLE_DEPTH_DEF];
  int                     occupancy;
  int                     misses;
  int                     wakes_seen;
  int                     rejects_seen;
  int                     wake_peak;

  task automatic post_mail(input logic [1:0] kind, input logic [ID_BITS_DEF-1:0] target,
                           input logic [TIME_W-1:0] stamp, input logic last);
    mail_t m;
    m.kind   = kind;
    m.target = target;
    m.stamp  = stamp;
    m.last   = last;
    pending_mail.push_back(m);
  endtask

  // Work out the results one accepted word causes and update the table.
  task automatic serve_request(input logic [1:0] cmd, input logic [ID_BITS_DEF-1:0] who,
                               input logic [TIME_W-1:0] span);
    logic [TIME_W-1:0] wake_at;
    mail_t             tail;
    int                woken;
    int                pos;
    woken   = 0;
    wake_at = clock_now + span;
    case (cmd)
      CMD_TICK: begin
        clock_now = clock_now + 1'b1;
        while (occupancy > 0 && woken < MAX_WAKES && slot_time[0] <= clock_now) begin
          post_mail(KIND_WAKE, slot_id[0], slot_time[0], 1'b0);
          woken++;
          for (int i = 1; i < occupancy; i++) begin
            slot_time[i-1] = slot_time[i];
            slot_id[i-1]   = slot_id[i];
          end
          occupancy--;
        end
        if (woken > 0) begin
          tail      = pending_mail.pop_back();
          tail.last = 1'b1;
          pending_mail.push_back(tail);
        end
        wakes_seen += woken;
        if (woken > wake_peak) wake_peak = woken;
      end
      CMD_QUERY: begin
        post_mail(KIND_TIME, who, clock_now, 1'b1);
      end
      CMD_SLEEP: begin
        if (occupancy >= TABLE_DEPTH_DEF) begin
          post_mail(KIND_REJECT, who, wake_at, 1'b1);
          rejects_seen++;
        end else begin
          // never slip in ahead of a head entry with the same wake time
          if (occupancy == 0 || wake_at < slot_time[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < occupancy && wake_at > slot_time[pos]) pos++;
          end
          for (int i = occupancy; i > pos; i--) begin
            slot_time[i] = slot_time[i-1];
            slot_id[i]   = slot_id[i-1];
          end
          slot_time[pos] = wake_at;
          slot_id[pos]   = who;
          occupancy++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_mail();
    mail_t want;
    if (pending_mail.size() == 0) begin
      if (misses < 10)
        $display("%0t: result kind %0d id %0d time %0d last %0d with nothing expected",
                 $time, out_kind, out_target_id, out_time_value, out_last);
      misses++;
    end else begin
      want = pending_mail.pop_front();
      if (out_kind !== want.kind || out_target_id !== want.target ||
          out_time_value !== want.stamp || out_last !== want.last) begin
        if (misses < 10)
          $display("%0t: expected kind %0d id %0d time %0d last %0d, got %0d %0d %0d %0d",
                   $time, want.kind, want.target, want.stamp, want.last,
                   out_kind, out_target_id, out_time_value, out_last);
        misses++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_mail.delete();
      clock_now    = RESET_TIME;
      occupancy    = 0;
      misses       = 0;
      wakes_seen   = 0;
      rejects_seen = 0;
      wake_peak    = 0;
    end else begin
      if (out_valid) check_mail();
      if (start && !busy) serve_request(in_cmd, in_requester_id, in_duration);
    end
    fail_count   <= misses;
    pending      <= pending_mail.size();
    wake_count   <= wakes_seen;
    reject_count <= rejects_seen;
    peak_wakes   <= wake_peak;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep timer queue testbench
// Drives directed and random tick, query and sleep words into the timer
// queue under several sender idling patterns; the result checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import stq_pkg::*;

  // the fourth command code is left unused by the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         ITEMS      = 330;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_cmd;
  logic [ID_BITS_DEF-1:0] in_requester_id;
  logic [TIME_W-1:0]      in_duration;
  logic                   out_valid;
  logic [1:0]             out_kind;
  logic [ID_BITS_DEF-1:0] out_target_id;
  logic [TIME_W-1:0]      out_time_value;
  logic                   out_last;

  int fail_count;
  int pending;
  int wake_count;
  int reject_count;
  int peak_wakes;

  int idle_pct;
  int words_sent;
  int n_ticks;
  int n_queries;
  int n_sleeps;

  sleep_timer_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_requester_id (in_requester_id),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_target_id   (out_target_id),
    .out_time_value  (out_time_value),
    .out_last        (out_last)
  );

  stq_mail_check u_mail_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_requester_id (in_requester_id),
    .in_duration     (in_duration),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_target_id   (out_target_id),
    .out_time_value  (out_time_value),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending),
    .wake_count      (wake_count),
    .reject_count    (reject_count),
    .peak_wakes      (peak_wakes)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("sleep_timer_queue test failed");
    $finish;
  end

  // Mostly short sleeps so the table drains; now and then a duration near the
  // top of the range, which wraps the wake time behind the current time.
  function automatic logic [TIME_W-1:0] pick_span();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (roll == 1) return '0;
    return $urandom_range(0, 10);
  endfunction

  // Offer one word and hold it until the block takes it. Called at a rising
  // edge; returns at the edge that took the word, start still high.
  task automatic send_word(input logic [1:0] cmd, input logic [ID_BITS_DEF-1:0] who,
                           input logic [TIME_W-1:0] span);
    bit took;
    // idle with junk on the fields while start is low
    while ($urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      in_cmd          <= 2'($urandom);
      in_requester_id <= ID_BITS_DEF'($urandom);
      in_duration     <= $urandom;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_requester_id <= who;
    in_duration     <= span;
    // sample busy mid-cycle, where it is settled for the coming edge
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    case (cmd)
      CMD_TICK:  n_ticks++;
      CMD_QUERY: n_queries++;
      CMD_SLEEP: n_sleeps++;
      default: ;
    endcase
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  // Hold the sender off until every predicted result has come out and the
  // block has gone quiet.
  task automatic drain_mail();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  initial begin
    int phase;
    int burst;
    int guard;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_cmd          <= CMD_TICK;
    in_requester_id <= '0;
    in_duration     <= '0;
    idle_pct   = 0;
    words_sent = 0;
    n_ticks    = 0;
    n_queries  = 0;
    n_sleeps   = 0;
    phase      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // time straight out of reset, lowest and highest mailbox
    send_word(CMD_QUERY, 8'h00, 32'h0000_0000);
    send_word(CMD_QUERY, 8'hFF, 32'hFFFF_FFFF);
    // unused command: no change, no result
    send_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    // tick on an empty table: time moves, nothing comes out
    send_word(CMD_TICK, 8'h00, 32'h0000_0000);
    // zero duration wakes on the next tick
    send_word(CMD_SLEEP, 8'hA5, 32'h0000_0000);
    // full-scale duration wraps behind now and lands ahead of the head
    send_word(CMD_SLEEP, 8'h5A, 32'hFFFF_FFFF);
    // equal wake times behind the head, then a later pair of equals
    send_word(CMD_SLEEP, 8'h01, 32'h0000_0000);
    send_word(CMD_SLEEP, 8'h02, 32'h0000_0003);
    send_word(CMD_SLEEP, 8'h03, 32'h0000_0003);
    // several due on one tick, then an empty tick, then the pair
    send_word(CMD_TICK, 8'h00, 32'h0000_0000);
    send_word(CMD_QUERY, 8'h7E, 32'h0000_0000);
    send_word(CMD_TICK, 8'h00, 32'h0000_0000);
    send_word(CMD_TICK, 8'h00, 32'h0000_0000);
    // a new entry equal to the head goes behind it; a smaller one goes first
    send_word(CMD_SLEEP, 8'h10, 32'h0000_0005);
    send_word(CMD_SLEEP, 8'h11, 32'h0000_0005);
    send_word(CMD_SLEEP, 8'h12, 32'h0000_0002);
    repeat (5) send_word(CMD_TICK, 8'h00, 32'h0000_0000);
    drain_mail();

    // ---- random part ----
    // fill the table to the brim with sleepers all due on the next tick:
    // the one over the top is turned away and the tick wakes a full burst
    repeat (TABLE_DEPTH_DEF + 1) send_word(CMD_SLEEP, ID_BITS_DEF'($urandom), '0);
    send_word(CMD_TICK, ID_BITS_DEF'($urandom), $urandom);

    while (words_sent < ITEMS) begin
      // advance the idling phase; drain first so each phase starts quiet
      if (words_sent * 4 / ITEMS != phase) begin
        phase = words_sent * 4 / ITEMS;
        drain_mail();
        case (phase)
          1:       idle_pct = 73;
          2:       idle_pct = 35;
          default: idle_pct = 0;
        endcase
      end
      // a burst of sleepers, now and then big enough to overflow the table
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 19) : $urandom_range(1, 6);
      repeat (burst) begin
        send_word(CMD_SLEEP, ID_BITS_DEF'($urandom), pick_span());
        if ($urandom_range(0, 5) == 0)
          send_word(CMD_QUERY, ID_BITS_DEF'($urandom), $urandom);
        if ($urandom_range(0, 11) == 0)
          send_word(CMD_UNUSED, ID_BITS_DEF'($urandom), $urandom);
      end
      // then let time run so the table drains
      repeat ($urandom_range(2, 14)) begin
        send_word(CMD_TICK, ID_BITS_DEF'($urandom), $urandom);
        if ($urandom_range(0, 4) == 0)
          send_word(CMD_QUERY, ID_BITS_DEF'($urandom), $urandom);
      end
    end

    // ---- wind down ----
    start <= 1'b0;
    guard = 0;
    while ((pending != 0 || busy) && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (24) @(posedge clk);

    $display("run covered %0d words: %0d ticks, %0d queries, %0d sleep requests",
             words_sent, n_ticks, n_queries, n_sleeps);
    $display("  %0d wake notices (up to %0d on one tick), %0d sleep rejects",
             wake_count, peak_wakes, reject_count);
    if (fail_count == 0 && pending == 0) begin
      $display("sleep_timer_queue test passed");
    end else begin
      $display("sleep_timer_queue test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/stq_pkg.sv
sv/stq_ctrl.sv
sv/stq_dp.sv
sv/sleep_timer_queue.sv
tb/stq_mail_check.sv
tb/testbench.sv
